// ===== rtl/sdpp_pkg.sv =====
// Shared types, constants and helpers for the sensor delta pair packer.
`default_nettype none

package sdpp_pkg;

   // Live width of the running data set count
   localparam int COUNT_WIDTH = 20;

   // Port field widths
   localparam int OP_W    = 2;
   localparam int SAMP_W  = 16;
   localparam int CNT_W   = 20;
   localparam int ADDR_W  = 21;
   localparam int DATA_W  = 32;
   localparam int POS_W   = 20;
   localparam int MODE_W  = 14;

   // Delta field widths inside a packed set
   localparam int TDELTA_W = 9;
   localparam int PDELTA_W = 7;
   localparam int SET_W    = TDELTA_W + PDELTA_W;

   // Mask applied to the incoming count
   localparam logic [CNT_W-1:0] COUNT_MASK =
      (COUNT_WIDTH >= CNT_W) ? {CNT_W{1'b1}}
                             : CNT_W'((64'd1 << COUNT_WIDTH) - 64'd1);

   typedef enum logic [OP_W-1:0] {
      OP_START   = 2'd0,
      OP_RECORD  = 2'd1,
      OP_FLUSH   = 2'd2,
      OP_ADVANCE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_UNSET = 2'd0,
      MODE_ONE   = 2'd1,
      MODE_TWO   = 2'd2,
      MODE_WIDE  = 2'd3
   } mode_type;

   localparam logic [MODE_W-1:0] MODE_WIDE_VALUE = MODE_W'(8192);

   // One result word as it leaves the block
   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] word_address;
      logic [DATA_W-1:0] word_data;
      logic              word_sent;
      logic [POS_W-1:0]  latest_position;
      logic [MODE_W-1:0] storage_mode;
      logic              last_result;
   } result_type;

   // Storage interval shown for a mode code
   function automatic logic [MODE_W-1:0] mode_value(input mode_type code);
      logic [MODE_W-1:0] val;
      case (code)
         MODE_ONE:  val = MODE_W'(1);
         MODE_TWO:  val = MODE_W'(2);
         MODE_WIDE: val = MODE_WIDE_VALUE;
         default:   val = '0;
      endcase
      return val;
   endfunction

   // Byte address of the word that holds data set 'count'
   function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] c;
      c = count & COUNT_MASK;
      return {c[CNT_W-1:1], 2'b00};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sdpp_engine.sv =====
// Per-request compute: delta packing, reference tracking and mode stepping.
`default_nettype none

module sdpp_engine
   import sdpp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              issue,
   input  wire logic [OP_W-1:0]   operation,
   input  wire logic [SAMP_W-1:0] temperature,
   input  wire logic [SAMP_W-1:0] pressure,
   input  wire logic [CNT_W-1:0]  sample_count,
   output result_type             first_res,
   output result_type             second_res,
   output logic                   two_results
);

   logic [SAMP_W-1:0] last_temp_ff, last_temp_in;
   logic [SAMP_W-1:0] last_pres_ff, last_pres_in;
   logic [SET_W-1:0]  held_set_ff, held_set_in;
   logic              held_valid_ff, held_valid_in;
   mode_type          mode_ff, mode_in;

   logic [CNT_W-1:0]    count_m;
   logic [CNT_W-1:0]    count_next;
   logic [TDELTA_W-1:0] tdelta;
   logic [PDELTA_W-1:0] pdelta;
   logic [SET_W-1:0]    new_set;
   logic [SAMP_W-1:0]   tdelta_sx;
   logic [SAMP_W-1:0]   pdelta_sx;

   // Wrapped deltas and their sign extension
   always_comb begin
      count_m    = sample_count & COUNT_MASK;
      count_next = (sample_count + CNT_W'(1)) & COUNT_MASK;
      tdelta     = TDELTA_W'(temperature - last_temp_ff);
      pdelta     = PDELTA_W'(pressure - last_pres_ff);
      new_set    = {pdelta, tdelta};
      tdelta_sx  = {{(SAMP_W-TDELTA_W){tdelta[TDELTA_W-1]}}, tdelta};
      pdelta_sx  = {{(SAMP_W-PDELTA_W){pdelta[PDELTA_W-1]}}, pdelta};
   end

   // Next state and results for the request at the head of the input register
   always_comb begin
      last_temp_in  = last_temp_ff;
      last_pres_in  = last_pres_ff;
      held_set_in   = held_set_ff;
      held_valid_in = held_valid_ff;
      mode_in       = mode_ff;
      two_results   = 1'b0;
      first_res     = '0;
      second_res    = '0;

      case (op_type'(operation))
         OP_START: begin
            last_temp_in  = temperature;
            last_pres_in  = pressure;
            held_valid_in = 1'b0;
            mode_in       = MODE_ONE;
            two_results   = 1'b1;
            first_res.write_enable  = 1'b1;
            first_res.word_address  = addr_of(count_m);
            first_res.word_data     = DATA_W'(mode_value(MODE_ONE));
            second_res.write_enable = 1'b1;
            second_res.word_address = addr_of(count_next);
            second_res.word_data    = {pressure, temperature};
            second_res.last_result  = 1'b1;
         end
         OP_RECORD: begin
            last_temp_in = last_temp_ff + tdelta_sx;
            last_pres_in = last_pres_ff + pdelta_sx;
            if (held_valid_ff) begin
               held_valid_in          = 1'b0;
               first_res.write_enable = 1'b1;
               first_res.word_address = addr_of(count_m);
               first_res.word_data    = {held_set_ff, new_set};
               first_res.word_sent    = 1'b1;
            end else begin
               held_set_in   = new_set;
               held_valid_in = 1'b1;
            end
            first_res.last_result = 1'b1;
         end
         OP_FLUSH: begin
            // held flag intentionally stays set
            if (held_valid_ff) begin
               first_res.write_enable    = 1'b1;
               first_res.word_address    = addr_of(count_m);
               first_res.word_data       = {held_set_ff, {SET_W{1'b0}}};
               first_res.latest_position = POS_W'(count_m);
            end else begin
               first_res.latest_position =
                  POS_W'((sample_count - CNT_W'(1)) & COUNT_MASK);
            end
            first_res.last_result = 1'b1;
         end
         OP_ADVANCE: begin
            mode_in = (mode_ff == MODE_ONE) ? MODE_TWO : MODE_WIDE;
            first_res.last_result = 1'b1;
         end
         default: begin
            first_res.last_result = 1'b1;
         end
      endcase

      first_res.storage_mode  = mode_value(mode_in);
      second_res.storage_mode = mode_value(mode_in);
   end

   // State registers, updated when a request issues
   always_ff @(posedge clock) begin
      if (reset) begin
         last_temp_ff  <= '0;
         last_pres_ff  <= '0;
         held_set_ff   <= '0;
         held_valid_ff <= 1'b0;
         mode_ff       <= MODE_UNSET;
      end else if (issue) begin
         last_temp_ff  <= last_temp_in;
         last_pres_ff  <= last_pres_in;
         held_set_ff   <= held_set_in;
         held_valid_ff <= held_valid_in;
         mode_ff       <= mode_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sdpp_outbuf.sv =====
// Result register with a second slot for the two-word start request.
`default_nettype none

module sdpp_outbuf
   import sdpp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire result_type  first_res,
   input  wire result_type  second_res,
   input  wire logic        two_results,
   input  wire logic        rsp_stall,
   output logic             rsp_valid,
   output result_type       rsp_res,
   output logic             can_load
);

   logic       out_valid_ff, out_valid_in;
   logic       pend_valid_ff, pend_valid_in;
   result_type out_ff, out_in;
   result_type pend_ff, pend_in;
   logic       take;

   // Room for a new request once the pending word is gone and the output drains
   assign take     = out_valid_ff && !rsp_stall;
   assign can_load = !pend_valid_ff && (!out_valid_ff || !rsp_stall);

   always_comb begin
      out_valid_in  = out_valid_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      pend_in       = pend_ff;
      if (load) begin
         out_valid_in  = 1'b1;
         out_in        = first_res;
         pend_valid_in = two_results;
         pend_in       = second_res;
      end else if (take) begin
         if (pend_valid_ff) begin
            out_in        = pend_ff;
            pend_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_ff;

endmodule

`default_nettype wire

// ===== rtl/sensor_delta_pair_packer_top.sv =====
// Top level of the sensor delta pair packer.
//
// Requests enter on req_* (valid/stall) and carry an operation, a sample pair
// and the running data set count. Results leave on rsp_* (valid/stall), one per
// request, two for a start request; rsp_last_result marks the final one.
// A request is taken into an input register, then passes through the compute
// logic into the result register, from which its first result is shown. One
// request per cycle is sustained while the receiver does not stall; a start
// request fills the pending slot too, and the next waits until it has drained.
// Reference samples, the held set and the storage mode are updated as the
// request moves from the input register into the result register.
// Reset clears the references and the held set, sets the mode to unset and
// empties both registers. While the receiver stalls, the shown result holds;
// the input register still takes one more request, then req_stall rises.
`default_nettype none

module sensor_delta_pair_packer_top
   import sdpp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [OP_W-1:0]   req_operation,
   input  wire logic [SAMP_W-1:0] req_temperature,
   input  wire logic [SAMP_W-1:0] req_pressure,
   input  wire logic [CNT_W-1:0]  req_sample_count,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_write_enable,
   output logic [ADDR_W-1:0]      rsp_word_address,
   output logic [DATA_W-1:0]      rsp_word_data,
   output logic                   rsp_word_sent,
   output logic [POS_W-1:0]       rsp_latest_position,
   output logic [MODE_W-1:0]      rsp_storage_mode,
   output logic                   rsp_last_result
);

   logic              in_valid_ff;
   logic [OP_W-1:0]   op_ff;
   logic [SAMP_W-1:0] temp_ff;
   logic [SAMP_W-1:0] pres_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              accept;
   logic              issue;
   logic              can_load;
   logic              two_results;
   result_type        first_res;
   result_type        second_res;
   result_type        rsp_res;

   // Handshake
   assign issue     = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !issue;
   assign accept    = req_valid && !req_stall;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (issue) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         temp_ff  <= req_temperature;
         pres_ff  <= req_pressure;
         count_ff <= req_sample_count;
      end
   end

   sdpp_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .issue        (issue),
      .operation    (op_ff),
      .temperature  (temp_ff),
      .pressure     (pres_ff),
      .sample_count (count_ff),
      .first_res    (first_res),
      .second_res   (second_res),
      .two_results  (two_results)
   );

   sdpp_outbuf u_outbuf (
      .clock       (clock),
      .reset       (reset),
      .load        (issue),
      .first_res   (first_res),
      .second_res  (second_res),
      .two_results (two_results),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_res     (rsp_res),
      .can_load    (can_load)
   );

   // Result fields
   assign rsp_write_enable    = rsp_res.write_enable;
   assign rsp_word_address    = rsp_res.word_address;
   assign rsp_word_data       = rsp_res.word_data;
   assign rsp_word_sent       = rsp_res.word_sent;
   assign rsp_latest_position = rsp_res.latest_position;
   assign rsp_storage_mode    = rsp_res.storage_mode;
   assign rsp_last_result     = rsp_res.last_result;

endmodule

`default_nettype wire

// ===== rtl/sdpp_checker.sv =====
// Port-level checks for the sensor delta pair packer, bound to the top level.
`default_nettype none

module sdpp_checker
   import sdpp_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic              rsp_write_enable,
   input wire logic [ADDR_W-1:0] rsp_word_address,
   input wire logic [DATA_W-1:0] rsp_word_data,
   input wire logic              rsp_word_sent,
   input wire logic [MODE_W-1:0] rsp_storage_mode,
   input wire logic              rsp_last_result
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_data)
                                 && $stable(rsp_last_result))
      else $error("stalled result changed");

   // No address or data without a write
   a_idle_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_word_address == '0 && rsp_word_data == '0)
      else $error("address or data without write enable");

   // A sent pair word is always a write
   a_sent_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_sent |-> rsp_write_enable && rsp_last_result)
      else $error("pair word sent without write");

   // Only the start header is a non-final result, and it carries mode one
   a_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |->
         rsp_write_enable && rsp_storage_mode == MODE_W'(1)
         && rsp_word_data == DATA_W'(1))
      else $error("malformed start header");

endmodule

bind sensor_delta_pair_packer_top sdpp_checker u_sdpp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_write_enable (rsp_write_enable),
   .rsp_word_address (rsp_word_address),
   .rsp_word_data    (rsp_word_data),
   .rsp_word_sent    (rsp_word_sent),
   .rsp_storage_mode (rsp_storage_mode),
   .rsp_last_result  (rsp_last_result)
);

`default_nettype wire
